// ----- rtl/core/rpn_pkg.sv -----
// ----------------------------------------------------------------------------
// rpn_pkg
// shared codes, widths and handshake types of the rpn stack evaluator
// ----------------------------------------------------------------------------
`default_nettype none

package rpn_pkg;

  localparam int DATA_W = 32;
  localparam int CNT_W  = 5;
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(DATA_W - 1);

  // token kinds
  localparam logic [2:0] FN_PUSH = 3'd0;
  localparam logic [2:0] FN_ADD  = 3'd1;
  localparam logic [2:0] FN_SUB  = 3'd2;
  localparam logic [2:0] FN_MUL  = 3'd3;
  localparam logic [2:0] FN_DIV  = 3'd4;

  // status codes
  localparam logic [2:0] ST_OK    = 3'd0;
  localparam logic [2:0] ST_UNDER = 3'd1;
  localparam logic [2:0] ST_OVER  = 3'd2;
  localparam logic [2:0] ST_DIVZ  = 3'd3;
  localparam logic [2:0] ST_COUNT = 3'd4;

  typedef struct packed {
    logic       start;
    logic [2:0] op;
  } alu_req_t;

  typedef struct packed {
    logic              done;
    logic [DATA_W-1:0] result;
  } alu_rsp_t;

endpackage

`default_nettype wire

// ----- rtl/core/rpn_alu.sv -----
// ----------------------------------------------------------------------------
// rpn_alu
// serial arithmetic unit: add and subtract one bit per cycle, multiply by
// shift and add, divide by restoring steps, 32 steps for every operation
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_alu (
  input  logic                          clk,
  input  logic                          rst,
  input  rpn_pkg::alu_req_t             req,
  input  logic [rpn_pkg::DATA_W-1:0]    left,
  input  logic [rpn_pkg::DATA_W-1:0]    right,
  output rpn_pkg::alu_rsp_t             rsp
);

  typedef enum logic [2:0] {
    A_IDLE = 3'b001,
    A_RUN  = 3'b010,
    A_FIN  = 3'b100
  } alu_state_t;

  alu_state_t state;

  logic [rpn_pkg::DATA_W-1:0] a;
  logic [rpn_pkg::DATA_W-1:0] b;
  logic [rpn_pkg::DATA_W-1:0] acc;
  logic [rpn_pkg::DATA_W-1:0] rem;
  logic                       carry;
  logic                       neg_q;
  logic [2:0]                 op;
  logic [rpn_pkg::CNT_W-1:0]  cnt;

  logic                       bb;
  logic                       sbit;
  logic                       cout;
  logic [rpn_pkg::DATA_W:0]   trial;
  logic [rpn_pkg::DATA_W-1:0] mul_sum;
  logic [rpn_pkg::DATA_W-1:0] left_mag;
  logic [rpn_pkg::DATA_W-1:0] right_mag;

  always_comb begin
    bb        = (op == rpn_pkg::FN_SUB) ? ~b[0] : b[0];
    sbit      = a[0] ^ bb ^ carry;
    cout      = (a[0] & bb) | (a[0] & carry) | (bb & carry);
    trial     = {rem, a[rpn_pkg::DATA_W-1]} - {1'b0, b};
    mul_sum   = acc + (b[0] ? a : '0);
    left_mag  = left[rpn_pkg::DATA_W-1] ? ('0 - left) : left;
    right_mag = right[rpn_pkg::DATA_W-1] ? ('0 - right) : right;
    rsp.done  = (state == A_FIN);
    // quotient builds up in a, sign applied on the way out
    if (op == rpn_pkg::FN_DIV) begin
      rsp.result = neg_q ? ('0 - a) : a;
    end else begin
      rsp.result = acc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= A_IDLE;
    end else begin
      case (state)
        A_IDLE: begin
          if (req.start) begin
            state <= A_RUN;
          end
        end
        A_RUN: begin
          if (cnt == rpn_pkg::CNT_LAST) begin
            state <= A_FIN;
          end
        end
        A_FIN: begin
          state <= A_IDLE;
        end
        default: begin
          state <= A_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == A_IDLE && req.start) begin
      op    <= req.op;
      cnt   <= '0;
      acc   <= '0;
      rem   <= '0;
      carry <= (req.op == rpn_pkg::FN_SUB);
      neg_q <= left[rpn_pkg::DATA_W-1] ^ right[rpn_pkg::DATA_W-1];
      if (req.op == rpn_pkg::FN_DIV) begin
        a <= left_mag;
        b <= right_mag;
      end else begin
        a <= left;
        b <= right;
      end
    end else if (state == A_RUN) begin
      cnt <= cnt + 1'b1;
      case (op)
        rpn_pkg::FN_ADD, rpn_pkg::FN_SUB: begin
          acc   <= {sbit, acc[rpn_pkg::DATA_W-1:1]};
          a     <= a >> 1;
          b     <= b >> 1;
          carry <= cout;
        end
        rpn_pkg::FN_MUL: begin
          acc <= mul_sum;
          a   <= a << 1;
          b   <= b >> 1;
        end
        rpn_pkg::FN_DIV: begin
          if (!trial[rpn_pkg::DATA_W]) begin
            rem <= trial[rpn_pkg::DATA_W-1:0];
            a   <= {a[rpn_pkg::DATA_W-2:0], 1'b1};
          end else begin
            rem <= {rem[rpn_pkg::DATA_W-2:0], a[rpn_pkg::DATA_W-1]};
            a   <= {a[rpn_pkg::DATA_W-2:0], 1'b0};
          end
        end
        default: begin
          acc <= acc;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rpn_stack_evaluator.sv -----
// ----------------------------------------------------------------------------
// rpn_stack_evaluator
// reverse polish expression evaluator over a stream of tokens
// ----------------------------------------------------------------------------
// input channel s_axis: one item per token, tuser is the token kind (push,
// add, subtract, multiply, divide), tdata the operand of a push, tlast marks
// the final token of an expression.
// output channel m_axis: one item per expression, tdata the value left on the
// stack (zero on error), tuser the sticky status of the expression.
// a push or an unknown kind is done when it is accepted. an operator goes
// through the accept, a stack memory read, 32 steps of the serial
// arithmetic unit and a write back; a divide by zero skips the
// arithmetic unit. the final token then loads the output register: a final
// push reaches the output through the emit state and the output register.
// the output register parts the two sides: tokens of the next expression are
// taken while a result waits; after a second final token the evaluator holds
// in its emit state until the receiver takes the first result.
// reset (synchronous) empties the stack, clears the status and drops any
// pending result. stack entries are not cleared and need no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_stack_evaluator #(
  parameter int STACK_DEPTH = 16
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // value
  input  logic [2:0]  s_axis_tuser,   // func
  input  logic        s_axis_tlast,   // last
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [31:0] m_axis_tdata,   // result
  output logic [2:0]  m_axis_tuser    // status
);

  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int AW = $clog2(STACK_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_LOAD = 4'b0010,
    S_CALC = 4'b0100,
    S_EMIT = 4'b1000
  } state_t;

  state_t state;

  logic [rpn_pkg::DATA_W-1:0] mem [STACK_DEPTH];
  logic [CW-1:0]              count;
  logic [2:0]                 err;
  logic [2:0]                 op;
  logic                       lst;
  logic [rpn_pkg::DATA_W-1:0] bottom;
  logic [rpn_pkg::DATA_W-1:0] rd_right;
  logic [rpn_pkg::DATA_W-1:0] rd_left;

  logic                       acc_in;
  logic                       is_op;
  logic                       full;
  logic                       two_ok;
  logic                       divz;
  logic                       out_ok;
  logic [CW-1:0]              count_m1;
  logic [CW-1:0]              count_m2;
  logic                       wr_en;
  logic [AW-1:0]              wr_addr;
  logic [rpn_pkg::DATA_W-1:0] wr_data;
  logic [2:0]                 st_out;
  rpn_pkg::alu_req_t          alu_req;
  rpn_pkg::alu_rsp_t          alu_rsp;

  rpn_alu u_alu (
    .clk   (clk),
    .rst   (rst),
    .req   (alu_req),
    .left  (rd_left),
    .right (rd_right),
    .rsp   (alu_rsp)
  );

  assign s_axis_tready = (state == S_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;
  assign out_ok        = !m_axis_tvalid || m_axis_tready;

  always_comb begin
    is_op    = s_axis_tuser inside {rpn_pkg::FN_ADD, rpn_pkg::FN_SUB,
                                    rpn_pkg::FN_MUL, rpn_pkg::FN_DIV};
    full     = (count == CW'(STACK_DEPTH));
    two_ok   = (count >= CW'(2));
    count_m1 = count - CW'(1);
    count_m2 = count - CW'(2);
    divz     = (op == rpn_pkg::FN_DIV) && (rd_right == '0);

    alu_req.start = (state == S_LOAD) && !divz;
    alu_req.op    = op;

    wr_en   = 1'b0;
    wr_addr = count[AW-1:0];
    wr_data = s_axis_tdata;
    if (acc_in && s_axis_tuser == rpn_pkg::FN_PUSH && !full) begin
      wr_en = 1'b1;
    end else if (state == S_LOAD && divz) begin
      wr_en   = 1'b1;
      wr_addr = count_m2[AW-1:0];
      wr_data = '0;
    end else if (state == S_CALC && alu_rsp.done) begin
      wr_en   = 1'b1;
      wr_addr = count_m2[AW-1:0];
      wr_data = alu_rsp.result;
    end

    if (err != rpn_pkg::ST_OK) begin
      st_out = err;
    end else if (count != CW'(1)) begin
      st_out = rpn_pkg::ST_COUNT;
    end else begin
      st_out = rpn_pkg::ST_OK;
    end
  end

  // stack memory: one write port, two registered read ports
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (acc_in && is_op && two_ok) begin
      rd_right <= mem[count_m1[AW-1:0]];
      rd_left  <= mem[count_m2[AW-1:0]];
    end
  end

  // bottom entry kept aside so the final result needs no extra read
  always_ff @(posedge clk) begin
    if (acc_in) begin
      op  <= s_axis_tuser;
      lst <= s_axis_tlast;
    end
    if (wr_en && ((state == S_IDLE && count == '0) ||
                  (state != S_IDLE && count == CW'(2)))) begin
      bottom <= wr_data;
    end
    if (state == S_EMIT && out_ok) begin
      m_axis_tuser <= st_out;
      m_axis_tdata <= (st_out == rpn_pkg::ST_OK) ? bottom : '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= S_IDLE;
      count         <= '0;
      err           <= rpn_pkg::ST_OK;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (state == S_EMIT && out_ok) begin
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (acc_in) begin
            if (s_axis_tuser == rpn_pkg::FN_PUSH) begin
              if (full) begin
                if (err == rpn_pkg::ST_OK) begin
                  err <= rpn_pkg::ST_OVER;
                end
              end else begin
                count <= count + CW'(1);
              end
            end else if (is_op && !two_ok && err == rpn_pkg::ST_OK) begin
              err <= rpn_pkg::ST_UNDER;
            end
            if (is_op && two_ok) begin
              state <= S_LOAD;
            end else if (s_axis_tlast) begin
              state <= S_EMIT;
            end
          end
        end
        S_LOAD: begin
          if (divz) begin
            if (err == rpn_pkg::ST_OK) begin
              err <= rpn_pkg::ST_DIVZ;
            end
            count <= count_m1;
            state <= lst ? S_EMIT : S_IDLE;
          end else begin
            state <= S_CALC;
          end
        end
        S_CALC: begin
          if (alu_rsp.done) begin
            count <= count_m1;
            state <= lst ? S_EMIT : S_IDLE;
          end
        end
        S_EMIT: begin
          if (out_ok) begin
            count <= '0;
            err   <= rpn_pkg::ST_OK;
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

// ----- rtl/core/rpn_chk.sv -----
// ----------------------------------------------------------------------------
// rpn_chk
// port level checks of the rpn stack evaluator, bound to the top level
// ----------------------------------------------------------------------------
`default_nettype none

module rpn_chk (
  input logic        clk,
  input logic        rst,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata,
  input logic [2:0]  m_axis_tuser
);

  // status is one of the defined codes
  a_status_code: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> (m_axis_tuser <= rpn_pkg::ST_COUNT))
    else $error("undefined status code on output");

  // any error status carries a zero result
  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != rpn_pkg::ST_OK) |-> (m_axis_tdata == 32'd0))
    else $error("nonzero result with error status");

  // a stalled item holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && !m_axis_tready) |=>
      (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
    else $error("output item changed while stalled");

  // reset drops any pending result
  a_rst_clear: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid right after reset");

endmodule

bind rpn_stack_evaluator rpn_chk u_rpn_chk (.*);

`default_nettype wire
